// ===== rtl/core/tfts_pkg.sv =====
// Shared types, constants and lookup functions for the text fold and tokenize block.
`default_nettype none

package tfts_pkg;

  localparam int TOKEN_BUFFER_DEPTH_DEF = 10;
  localparam int LONGEST_SYNONYM        = 10;
  localparam int NUM_SYN                = 6;
  localparam int LEN_W                  = $clog2(LONGEST_SYNONYM + 1);

  localparam logic [6:0] CH_NUL   = 7'h00;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_9     = 7'h39;
  localparam logic [6:0] CH_LA    = 7'h61;
  localparam logic [6:0] CH_LC    = 7'h63;
  localparam logic [6:0] CH_LE    = 7'h65;
  localparam logic [6:0] CH_LI    = 7'h69;
  localparam logic [6:0] CH_LO    = 7'h6f;
  localparam logic [6:0] CH_LU    = 7'h75;
  localparam logic [6:0] CH_LZ    = 7'h7a;

  localparam logic [7:0] BYTE_UA     = 8'h41;
  localparam logic [7:0] BYTE_UZ     = 8'h5a;
  localparam logic [7:0] BYTE_ASCII  = 8'h80;
  localparam logic [7:0] BYTE_CONT_H = 8'hbf;
  localparam logic [7:0] BYTE_LEAD   = 8'hc3;

  localparam logic [LEN_W-1:0] LEN_GRAPE  = LEN_W'(10);
  localparam logic [LEN_W-1:0] LEN_SESAME = LEN_W'(6);

  // Words are left-aligned in 80 bits, first character in the top byte.
  localparam logic [79:0] WORD_GRAPE  = "grapefruit";
  localparam logic [79:0] WORD_SESAME = {"sesame", 32'h0};

  localparam logic [79:0] KEY_TORANJA  = {"toranja", 24'h0};
  localparam logic [79:0] KEY_POMELO   = {"pomelo", 32'h0};
  localparam logic [79:0] KEY_GRAPE    = "grapefruit";
  localparam logic [79:0] KEY_GERGELIM = {"gergelim", 16'h0};
  localparam logic [79:0] KEY_SESAME   = {"sesame", 32'h0};
  localparam logic [79:0] KEY_SESAMO   = {"sesamo", 32'h0};

  typedef enum logic [1:0] {
    SRC_BUF,
    SRC_GRAPE,
    SRC_SESAME
  } body_src_t;

  typedef struct packed {
    logic             shift;
    logic             wr;
    logic [LEN_W-1:0] wr_idx;
    logic [6:0]       wr_char;
  } chain_ctl_t;

  function automatic logic [6:0] pick_char(input logic [79:0] w, input logic [3:0] i);
    logic [79:0] s;
    s = w << {i, 3'b000};
    return s[78:72];
  endfunction

  function automatic logic [79:0] key_word(input logic [2:0] k);
    logic [79:0] w;
    case (k)
      3'd0:    w = KEY_TORANJA;
      3'd1:    w = KEY_POMELO;
      3'd2:    w = KEY_GRAPE;
      3'd3:    w = KEY_GERGELIM;
      3'd4:    w = KEY_SESAME;
      default: w = KEY_SESAMO;
    endcase
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] key_len(input logic [2:0] k);
    logic [LEN_W-1:0] n;
    case (k)
      3'd0:    n = LEN_W'(7);
      3'd1:    n = LEN_W'(6);
      3'd2:    n = LEN_W'(10);
      3'd3:    n = LEN_W'(8);
      default: n = LEN_W'(6);
    endcase
    return n;
  endfunction

  // Second byte after the 0xC3 lead; the table repeats for upper and lower case.
  function automatic logic [6:0] fold_char(input logic [4:0] lo);
    logic [6:0] r;
    case (lo) inside
      [5'd0:5'd4]:   r = CH_LA;
      5'd7:          r = CH_LC;
      [5'd8:5'd11]:  r = CH_LE;
      [5'd12:5'd15]: r = CH_LI;
      [5'd18:5'd22]: r = CH_LO;
      [5'd25:5'd28]: r = CH_LU;
      default:       r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tfts_cell.sv =====
// One token buffer cell: holds a character, loads it by index, shifts toward the head.
`default_nettype none

module tfts_cell
  import tfts_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire chain_ctl_t ctl,
  input  wire logic [6:0] nbr_char,
  output logic      [6:0] char_q
);

  localparam logic             WRITABLE = (IDX < LONGEST_SYNONYM);
  localparam logic [LEN_W-1:0] MY_IDX   = LEN_W'(IDX);

  logic [6:0] char_r;
  logic [6:0] char_nxt;

  always_comb begin
    char_nxt = char_r;
    if (ctl.shift) begin
      char_nxt = nbr_char;
    end else if (WRITABLE && ctl.wr && (ctl.wr_idx == MY_IDX)) begin
      char_nxt = ctl.wr_char;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

`default_nettype wire

// ===== rtl/core/tfts_ctrl.sv =====
// Byte decode, token state, synonym tracking and the output beat sequencer.
`default_nettype none

module tfts_ctrl
  import tfts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eot,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [6:0] out_char,
  output logic            out_end,
  output logic            out_last,
  output chain_ctl_t      chain_ctl,
  input  wire logic [6:0] chain_head
);

  logic               pending_r, pending_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               passing_r, passing_nxt;
  logic               seen_r, seen_nxt;
  logic [NUM_SYN-1:0] match_r, match_nxt;

  logic               sp_r, sp_nxt;
  logic [LEN_W-1:0]   body_cnt_r, body_cnt_nxt;
  body_src_t          body_src_r, body_src_nxt;
  logic [3:0]         body_idx_r, body_idx_nxt;
  logic               chp_r, chp_nxt;
  logic [6:0]         chv_r, chv_nxt;
  logic               term_r, term_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_char_r, out_char_nxt;
  logic               out_end_r, out_end_nxt;
  logic               out_last_r, out_last_nxt;

  logic               busy;
  logic               accept;
  logic               emit;
  logic               have_c;
  logic [6:0]         c;
  logic               alnum;
  logic [6:0]         fc;
  logic               hit_grape;
  logic               hit_sesame;
  logic               do_flush;
  logic               rem;

  assign busy     = sp_r || (body_cnt_r != '0) || chp_r || term_r;
  assign in_ready = !busy;
  assign accept   = in_valid && !busy;
  assign emit     = busy && (!out_valid_r || out_ready);

  // Character decode, including the two-byte accented fold.
  always_comb begin
    fc          = fold_char(in_byte[4:0]);
    have_c      = 1'b0;
    c           = in_byte[6:0];
    pending_nxt = pending_r;
    if (accept && !in_eot) begin
      pending_nxt = 1'b0;
      if (pending_r && (in_byte >= BYTE_ASCII) && (in_byte <= BYTE_CONT_H) &&
          (fc != CH_NUL)) begin
        have_c = 1'b1;
        c      = fc;
      end else if (in_byte < BYTE_ASCII) begin
        have_c = 1'b1;
        c      = (in_byte >= BYTE_UA && in_byte <= BYTE_UZ) ? (in_byte[6:0] | CH_SPACE)
                                                            : in_byte[6:0];
      end else if (in_byte == BYTE_LEAD) begin
        pending_nxt = 1'b1;
      end
    end else if (accept) begin
      pending_nxt = 1'b0;
    end
    alnum = (c inside {[CH_0:CH_9], [CH_LA:CH_LZ]});
  end

  always_comb begin
    hit_grape  = 1'b0;
    hit_sesame = 1'b0;
    for (int k = 0; k < NUM_SYN; k++) begin
      if (match_r[k] && (len_r == key_len(3'(k)))) begin
        if (k >= NUM_SYN / 2) hit_sesame = 1'b1;
        else                  hit_grape  = 1'b1;
      end
    end
  end

  always_comb begin
    len_nxt       = len_r;
    passing_nxt   = passing_r;
    seen_nxt      = seen_r;
    match_nxt     = match_r;
    sp_nxt        = sp_r;
    body_cnt_nxt  = body_cnt_r;
    body_src_nxt  = body_src_r;
    body_idx_nxt  = body_idx_r;
    chp_nxt       = chp_r;
    chv_nxt       = chv_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    chain_ctl     = '{shift: 1'b0, wr: 1'b0, wr_idx: len_r, wr_char: c};
    rem           = 1'b0;
    do_flush      = accept && (in_eot || (have_c && !alnum));

    if (do_flush) begin
      if (passing_r) begin
        passing_nxt = 1'b0;
      end else if (len_r != '0) begin
        sp_nxt       = seen_r;
        body_idx_nxt = '0;
        if (hit_sesame) begin
          body_src_nxt = SRC_SESAME;
          body_cnt_nxt = LEN_SESAME;
        end else if (hit_grape) begin
          body_src_nxt = SRC_GRAPE;
          body_cnt_nxt = LEN_GRAPE;
        end else begin
          body_src_nxt = SRC_BUF;
          body_cnt_nxt = len_r;
        end
        seen_nxt = 1'b1;
        len_nxt  = '0;
      end
      if (in_eot) begin
        term_nxt    = 1'b1;
        len_nxt     = '0;
        passing_nxt = 1'b0;
        seen_nxt    = 1'b0;
      end
    end else if (accept && have_c) begin
      if (passing_r) begin
        chp_nxt = 1'b1;
        chv_nxt = c;
      end else if (len_r < LEN_W'(LONGEST_SYNONYM)) begin
        chain_ctl.wr = 1'b1;
        len_nxt      = LEN_W'(len_r + 1'b1);
        // Each flag says the token so far is a prefix of that key.
        for (int k = 0; k < NUM_SYN; k++) begin
          match_nxt[k] = ((len_r == '0) || match_r[k]) && (len_r < key_len(3'(k))) &&
                         (c == pick_char(key_word(3'(k)), len_r));
        end
      end else begin
        // Too long for any key: release the buffer and stream from here on.
        sp_nxt       = seen_r;
        body_src_nxt = SRC_BUF;
        body_cnt_nxt = len_r;
        body_idx_nxt = '0;
        chp_nxt      = 1'b1;
        chv_nxt      = c;
        seen_nxt     = 1'b1;
        passing_nxt  = 1'b1;
        len_nxt      = '0;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_end_nxt   = 1'b0;
      if (sp_r) begin
        out_char_nxt = CH_SPACE;
        sp_nxt       = 1'b0;
        rem          = (body_cnt_r != '0) || chp_r || term_r;
      end else if (body_cnt_r != '0) begin
        case (body_src_r)
          SRC_GRAPE:  out_char_nxt = pick_char(WORD_GRAPE, body_idx_r);
          SRC_SESAME: out_char_nxt = pick_char(WORD_SESAME, body_idx_r);
          default:    out_char_nxt = chain_head;
        endcase
        chain_ctl.shift = (body_src_r == SRC_BUF);
        body_cnt_nxt    = LEN_W'(body_cnt_r - 1'b1);
        body_idx_nxt    = body_idx_r + 4'd1;
        rem             = (body_cnt_r != LEN_W'(1)) || chp_r || term_r;
      end else if (chp_r) begin
        out_char_nxt = chv_r;
        chp_nxt      = 1'b0;
        rem          = term_r;
      end else begin
        out_char_nxt = CH_NUL;
        out_end_nxt  = 1'b1;
        term_nxt     = 1'b0;
        rem          = 1'b0;
      end
      out_last_nxt = !rem;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      len_r       <= '0;
      passing_r   <= 1'b0;
      seen_r      <= 1'b0;
      sp_r        <= 1'b0;
      body_cnt_r  <= '0;
      chp_r       <= 1'b0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      len_r       <= len_nxt;
      passing_r   <= passing_nxt;
      seen_r      <= seen_nxt;
      sp_r        <= sp_nxt;
      body_cnt_r  <= body_cnt_nxt;
      chp_r       <= chp_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r    <= match_nxt;
    body_src_r <= body_src_nxt;
    body_idx_r <= body_idx_nxt;
    chv_r      <= chv_nxt;
    out_char_r <= out_char_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_end   = out_end_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/text_fold_tokenize_synonym.sv =====
// Top level: UTF-8 fold, tokenizer and synonym replacement over a chain of buffer cells.
//
//   Channel  Direction  tdata          tuser        tlast
//   in_      slave      in_byte[7:0]   end_of_text  -
//   out_     master     out_char[6:0]  is_text_end  last_of_run
//
// An item that only updates state (stored character, lead byte, dropped byte) makes
// no beats; for an item with result beats the sequencer puts out one beat per cycle
// while the output is not stalled, through a single output register, and the token
// cells shift one character toward the head per beat. Up to 12 beats follow one item.
// Reset is synchronous, active low, and clears control state; the cells need none.
// A stalled output holds its beat and the sequencer waits; input is taken again once
// the last beat of the previous item sits in the output register.
`default_nettype none

module text_fold_tokenize_synonym
  import tfts_pkg::*;
#(
  parameter int TOKEN_BUFFER_DEPTH = TOKEN_BUFFER_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tuser,   // [0] end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic            out_tuser,  // [0] is_text_end
  output logic            out_tlast
);

  chain_ctl_t chain_ctl;
  logic [6:0] cell_q [TOKEN_BUFFER_DEPTH];
  logic [6:0] out_char;

  for (genvar i = 0; i < TOKEN_BUFFER_DEPTH; i++) begin : g_cell
    logic [6:0] nbr;
    if (i == TOKEN_BUFFER_DEPTH - 1) begin : g_tail
      assign nbr = CH_NUL;
    end else begin : g_link
      assign nbr = cell_q[i+1];
    end
    tfts_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (chain_ctl),
      .nbr_char (nbr),
      .char_q   (cell_q[i])
    );
  end

  tfts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_eot     (in_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_end    (out_tuser),
    .out_last   (out_tlast),
    .chain_ctl  (chain_ctl),
    .chain_head (cell_q[0])
  );

  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// ===== tb/tb_text_fold_tokenize_synonym.sv =====
// Self-checking testbench for the UTF-8 fold, tokenizer and synonym stream block.
`default_nettype none

module tb_text_fold_tokenize_synonym;
  timeunit 1ns;
  timeprecision 1ps;

  import tfts_pkg::*;

  localparam int BUF_DEPTH     = 10;
  localparam int WATCHDOG_IDLE = 2000;
  localparam int RANDOM_ITEMS  = 470;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [7:0]  data;
    logic        eot;
    int unsigned gap;
    bit          hold;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tuser = 1'b0;    // [0] end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [6:0] out_char, [7] zero
  logic       out_tuser;          // [0] is_text_end
  logic       out_tlast;

  text_fold_tokenize_synonym dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic        lead_wait;
  logic [6:0]  word_buf [BUF_DEPTH];
  int unsigned word_len;
  bit          streaming;
  bit          any_token;
  string       syn_word [6] = '{"toranja", "pomelo", "grapefruit",
                                "gergelim", "sesame", "sesamo"};

  text_beat_t  run_q [$];
  text_beat_t  folded_q [$];
  text_item_t  item_q [$];

  int unsigned in_beats, out_beats, errors, idle_cycles;
  int unsigned texts_done, long_tokens, swaps_done;

  // Stimulus pacing.
  int unsigned tx_mode, tx_mode_left;
  bit          hold_next;

  task automatic emit(input logic [6:0] c, input logic fin);
    text_beat_t b;
    b.ch   = c;
    b.fin  = fin;
    b.last = 1'b0;
    run_q = {run_q, b};
  endtask

  // Second byte after a 0xC3 lead; zero means it does not fold.
  function automatic logic [6:0] fold_second(input logic [7:0] b);
    logic [6:0] r;
    r = 7'h00;
    if (b[7:6] == 2'b10) begin
      case (b[4:0])
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4:    r = CH_LA;
        5'd7:                            r = CH_LC;
        5'd8, 5'd9, 5'd10, 5'd11:        r = CH_LE;
        5'd12, 5'd13, 5'd14, 5'd15:      r = CH_LI;
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22: r = CH_LO;
        5'd25, 5'd26, 5'd27, 5'd28:      r = CH_LU;
        default:                         r = 7'h00;
      endcase
    end
    return r;
  endfunction

  function automatic int match_key();
    bit  hit;
    byte k_ch;
    for (int k = 0; k < 6; k++) begin
      if (syn_word[k].len() == word_len) begin
        hit = 1'b1;
        for (int i = 0; i < word_len; i++) begin
          k_ch = syn_word[k][i];
          if (k_ch[6:0] != word_buf[i]) hit = 1'b0;
        end
        if (hit) return k;
      end
    end
    return -1;
  endfunction

  task automatic flush_word();
    int    k;
    string swap;
    byte   s_ch;
    if (streaming) begin
      streaming = 1'b0;
    end else if (word_len != 0) begin
      if (any_token) emit(CH_SPACE, 1'b0);
      k = match_key();
      if (k >= 0) begin
        if (k >= 3) swap = "sesame";
        else swap = "grapefruit";
        for (int i = 0; i < swap.len(); i++) begin
          s_ch = swap[i];
          emit(s_ch[6:0], 1'b0);
        end
        swaps_done++;
      end else begin
        for (int i = 0; i < word_len; i++) emit(word_buf[i], 1'b0);
      end
      any_token = 1'b1;
      word_len  = 0;
    end
  endtask

  task automatic take_char(input logic [6:0] c);
    bit alnum;
    alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z");
    if (!alnum) begin
      flush_word();
    end else if (streaming) begin
      emit(c, 1'b0);
    end else if (word_len < BUF_DEPTH) begin
      word_buf[word_len] = c;
      word_len++;
    end else begin
      // Eleventh character: nothing can match any more, so the word goes out now.
      if (any_token) emit(CH_SPACE, 1'b0);
      for (int i = 0; i < word_len; i++) emit(word_buf[i], 1'b0);
      emit(c, 1'b0);
      word_len  = 0;
      any_token = 1'b1;
      streaming = 1'b1;
      long_tokens++;
    end
  endtask

  task automatic clear_state();
    lead_wait = 1'b0;
    word_len  = 0;
    streaming = 1'b0;
    any_token = 1'b0;
  endtask

  task automatic fold_step(input logic [7:0] b_in, input logic eot);
    logic [8:0] b;
    logic [6:0] f;
    run_q.delete();
    b = {1'b0, b_in};
    if (eot) begin
      flush_word();
      emit(7'h00, 1'b1);
      clear_state();
      texts_done++;
    end else begin
      if (lead_wait) begin
        lead_wait = 1'b0;
        f = fold_second(b_in);
        if (f != 7'h00) begin
          take_char(f);
          b = 9'h100;
        end
      end
      if (b < 9'h080) begin
        if (b >= 9'h041 && b <= 9'h05a) b = b + 9'd32;
        take_char(b[6:0]);
      end else if (b == 9'h0c3) begin
        lead_wait = 1'b1;
      end
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    folded_q = {folded_q, run_q};
  endtask

  task automatic report_miss(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Checker, predictor feed and watchdog, all on the rising edge.
  always @(posedge clk) begin
    text_beat_t want;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        out_beats++;
        if (folded_q.size() == 0) begin
          report_miss($sformatf("unexpected beat char=%02h end=%0b last=%0b",
                                out_tdata, out_tuser, out_tlast));
        end else begin
          want = folded_q.pop_front();
          if (out_tdata !== {1'b0, want.ch} || out_tuser !== want.fin ||
              out_tlast !== want.last)
            report_miss($sformatf("beat %0d exp char=%02h end=%0b last=%0b, got %02h %0b %0b",
                                  out_beats, {1'b0, want.ch}, want.fin, want.last,
                                  out_tdata, out_tuser, out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        in_beats++;
        fold_step(in_tdata, in_tuser);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_IDLE) begin
        $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, folded_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Sender: one item from the queue at a time, with its own gap before it.
  text_item_t  cur_item;
  bit          tx_loaded;
  int unsigned tx_sent, tx_wait;

  always @(negedge clk) begin
    logic v;
    v = in_tvalid;
    if (!rst_n) begin
      v = 1'b0;
    end else begin
      if (v && in_beats != tx_sent) begin
        tx_sent++;
        v = 1'b0;
      end
      if (!v && (tx_loaded || item_q.size() > 0)) begin
        if (!tx_loaded) begin
          cur_item  = item_q.pop_front();
          tx_wait   = cur_item.gap;
          tx_loaded = 1'b1;
        end
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (!cur_item.hold || folded_q.size() == 0) begin
          v         = 1'b1;
          in_tdata <= cur_item.data;
          in_tuser <= cur_item.eot;
          tx_loaded = 1'b0;
        end
      end
    end
    in_tvalid <= v;
  end

  // Receiver: after each accepted beat, draw a random wait during which ready is dropped.
  int unsigned rx_seen, rx_wait, rx_mode, rx_mode_left;

  always @(negedge clk) begin
    logic r;
    r = 1'b0;
    if (rst_n) begin
      if (out_beats != rx_seen) begin
        rx_seen = out_beats;
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(20, 80);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       rx_wait = 0;
          1:       rx_wait = $urandom_range(0, 14);
          default: rx_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
      end
      if (rx_wait > 0) rx_wait--;
      else r = 1'b1;
    end
    out_tready <= r;
  end

  task automatic add_item(input logic [7:0] b, input logic eot);
    text_item_t it;
    if (tx_mode_left == 0) begin
      tx_mode      = $urandom_range(0, 2);
      tx_mode_left = $urandom_range(20, 60);
    end
    tx_mode_left--;
    it.data = b;
    it.eot  = eot;
    it.hold = hold_next;
    hold_next = 1'b0;
    case (tx_mode)
      0:       it.gap = 0;
      1:       it.gap = $urandom_range(0, 14);
      default: it.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endcase
    item_q = {item_q, it};
  endtask

  // One character of a word, sometimes uppercased, accented or with a stray byte after it.
  task automatic add_letter(input logic [6:0] c);
    int unsigned r;
    logic [4:0]  lo;
    logic [7:0]  stray;
    r = $urandom_range(0, 9);
    if ((c == "a" || c == "c" || c == "e" || c == "i" || c == "o" || c == "u") && r < 3) begin
      case (c)
        "a":     lo = 5'($urandom_range(0, 4));
        "c":     lo = 5'd7;
        "e":     lo = 5'($urandom_range(8, 11));
        "i":     lo = 5'($urandom_range(12, 15));
        "o":     lo = 5'($urandom_range(18, 22));
        default: lo = 5'($urandom_range(25, 28));
      endcase
      add_item(BYTE_LEAD, 1'b0);
      add_item({2'b10, 1'($urandom_range(0, 1)), lo}, 1'b0);
    end else if (c >= "a" && c <= "z" && r < 5) begin
      add_item({1'b0, c} - 8'd32, 1'b0);
    end else begin
      add_item({1'b0, c}, 1'b0);
    end
    if ($urandom_range(0, 19) == 0) begin
      stray = 8'($urandom_range(128, 255));
      if (stray == BYTE_LEAD) stray = 8'hc2;
      add_item(stray, 1'b0);
    end
  endtask

  function automatic logic [6:0] pick_alnum();
    int unsigned r;
    r = $urandom_range(0, 35);
    return (r < 26) ? 7'("a" + r) : 7'("0" + r - 26);
  endfunction

  task automatic add_word();
    int unsigned kind, n;
    logic [6:0]  w [$];
    byte         k_ch;
    string       key;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      key = syn_word[$urandom_range(0, 5)];
      for (int i = 0; i < key.len(); i++) begin
        k_ch = key[i];
        w = {w, k_ch[6:0]};
      end
      // Near misses: one character more or one less than a key.
      if (kind == 3) begin
        if ($urandom_range(0, 1)) w = {w, pick_alnum()};
        else void'(w.pop_back());
      end
    end else begin
      case (kind)
        4:       n = $urandom_range(11, 16);
        5:       n = 10;
        default: n = $urandom_range(1, 9);
      endcase
      repeat (n) w = {w, pick_alnum()};
    end
    foreach (w[i]) add_letter(w[i]);
  endtask

  task automatic add_separator();
    int unsigned r;
    logic [7:0]  b;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 9);
      if (r <= 4) begin
        add_item(" ", 1'b0);
      end else if (r <= 6) begin
        b = 8'($urandom_range(8'h00, 8'h2f));
        add_item(b, 1'b0);
      end else if (r == 7) begin
        b = 8'($urandom_range(8'h5b, 8'h60));
        if ($urandom_range(0, 1)) b = 8'($urandom_range(8'h7b, 8'h7f));
        add_item(b, 1'b0);
      end else if (r == 8) begin
        add_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // Lead byte with a random follower that usually does not fold.
        add_item(BYTE_LEAD, 1'b0);
        add_item(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task automatic add_text(input bit closing);
    int unsigned words;
    words = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) add_separator();
    for (int i = 0; i < words; i++) begin
      add_word();
      if (i < words - 1 || $urandom_range(0, 1)) add_separator();
    end
    if ($urandom_range(0, 7) == 0) add_item(BYTE_LEAD, 1'b0);
    if (closing || $urandom_range(0, 9) != 0) add_item(8'($urandom_range(0, 255)), 1'b1);
    else add_separator();
  endtask

  initial begin
    int unsigned n_text;
    clear_state();
    // Directed part: empty text, field extremes, leads in odd places.
    add_item(8'h00, 1'b1);
    hold_next = 1'b1;
    add_item("A", 1'b0);
    add_item("Z", 1'b0);
    add_item("0", 1'b0);
    add_item("9", 1'b0);
    add_item("z", 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(8'ha7, 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(8'h41, 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(8'hbf, 1'b0);
    add_item(8'h7f, 1'b0);
    add_item(8'h80, 1'b0);
    add_item("x", 1'b0);
    add_item(BYTE_LEAD, 1'b0);
    add_item(8'hff, 1'b1);

    n_text = 0;
    while (item_q.size() < RANDOM_ITEMS + 21) begin
      if (n_text % 7 == 3) hold_next = 1'b1;
      add_text(1'b0);
      n_text++;
    end
    add_text(1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (item_q.size() != 0 || tx_loaded || in_tvalid) @(posedge clk);
    while (folded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats over %0d texts; checked %0d output beats.",
             in_beats, texts_done, out_beats);
    $display("Synonym swaps: %0d, long tokens streamed: %0d, mismatches: %0d.",
             swaps_done, long_tokens, errors);
    if (errors == 0 && folded_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
